@@ design/key_tap_hold_pattern_detector_macros.svh @@
// ----------------------------------------------------------------------------
// key_tap_hold_pattern_detector_macros
// assertion macros used by the checker file kthpd_checker
// ----------------------------------------------------------------------------
`ifndef KEY_TAP_HOLD_PATTERN_DETECTOR_MACROS_SVH
`define KEY_TAP_HOLD_PATTERN_DETECTOR_MACROS_SVH

// same-cycle implication, held off during reset
`define KTHPD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, held off during reset
`define KTHPD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ design/kthpd_pkg.sv @@
// ----------------------------------------------------------------------------
// kthpd_pkg
// types, codes and reset values of the key tap/hold pattern detector
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package kthpd_pkg;

    localparam int MAX_SYMBOLS_DEF = 32;
    localparam int KEY_W           = 10;
    localparam int PAT_W           = 32;
    localparam int LEN_W           = 6;
    localparam int ADDR_W          = 4;
    localparam int DATA_W          = 32;

    localparam logic [1:0] REG_REPEAT_INTERVAL = 2'd0;
    localparam logic [1:0] REG_TIMEOUT_TICKS   = 2'd1;
    localparam logic [1:0] REG_ACTION_KEY      = 2'd2;

    localparam logic [7:0]       REPEAT_INTERVAL_RST = 8'd10;
    localparam logic [15:0]      TIMEOUT_TICKS_RST   = 16'd300;
    localparam logic [KEY_W-1:0] ACTION_KEY_RST      = 10'd34;

    localparam logic [7:0] HOLD_COUNT_MAX = 8'd255;

    localparam logic REQ_KEY  = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    localparam logic [1:0] KEY_RELEASE = 2'd0;
    localparam logic [1:0] KEY_PRESS   = 2'd1;
    localparam logic [1:0] KEY_REPEAT  = 2'd2;

    typedef enum logic [2:0] {
        ACT_NONE       = 3'd0,
        ACT_PLAY_PAUSE = 3'd1,
        ACT_PREVIOUS   = 3'd2,
        ACT_NEXT       = 3'd3,
        ACT_SEEK_FWD   = 3'd4
    } action_t;

    typedef struct packed {
        logic             req_type;
        logic [KEY_W-1:0] key_code;
        logic [1:0]       key_value;
    } evt_t;

    typedef struct packed {
        action_t          action;
        logic             report_valid;
        logic [KEY_W-1:0] report_key;
        logic [PAT_W-1:0] pattern_bits;
        logic [LEN_W-1:0] pattern_len;
    } res_t;

    typedef struct packed {
        logic [7:0]       repeat_interval;
        logic [15:0]      timeout_ticks;
        logic [KEY_W-1:0] action_key;
    } cfg_t;

    typedef struct packed {
        logic [KEY_W-1:0] last_key;
        logic             key_seen;
        logic [7:0]       hold_count;
        logic [7:0]       hold_phase;
        logic [15:0]      timeout_left;
        logic             timeout_armed;
    } ctl_state_t;

endpackage

@@ design/kthpd_step.sv @@
// ----------------------------------------------------------------------------
// kthpd_step
// next-state and result logic for one event or tick
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kthpd_step #(
    parameter int MAX_SYMBOLS = kthpd_pkg::MAX_SYMBOLS_DEF
) (
    input  kthpd_pkg::cfg_t                           cfg,
    input  kthpd_pkg::evt_t                           evt,
    input  kthpd_pkg::ctl_state_t                     st,
    input  logic [MAX_SYMBOLS-1:0]                    sym_bits,
    input  logic [$clog2(MAX_SYMBOLS+1)-1:0]          sym_count,
    output kthpd_pkg::ctl_state_t                     st_next,
    output logic [MAX_SYMBOLS-1:0]                    sym_bits_next,
    output logic [$clog2(MAX_SYMBOLS+1)-1:0]          sym_count_next,
    output kthpd_pkg::res_t                           res
);
    import kthpd_pkg::*;

    localparam int CNT_W = $clog2(MAX_SYMBOLS + 1);
    localparam logic [MAX_SYMBOLS-1:0] BITS_ONE = MAX_SYMBOLS'(1);

    logic [7:0]             iv;
    logic [8:0]             phase_inc;
    logic [7:0]             phase_adv;
    logic [7:0]             count_adv;
    logic                   key_clear;
    logic                   long_hold;
    logic [15:0]            tl_dec;
    logic [MAX_SYMBOLS-1:0] bits_w;
    logic [CNT_W-1:0]       cnt_w;
    logic [PAT_W-1:0]       pat_ext;
    logic [LEN_W-1:0]       len_ext;
    action_t                act;
    logic                   rep;

    assign iv        = (cfg.repeat_interval == 8'd0) ? 8'd1 : cfg.repeat_interval;
    assign phase_inc = {1'b0, st.hold_phase} + 9'd1;
    assign phase_adv = (phase_inc >= {1'b0, iv}) ? 8'd0 : phase_inc[7:0];
    assign count_adv = (st.hold_count < HOLD_COUNT_MAX) ? st.hold_count + 8'd1
                                                        : st.hold_count;
    assign key_clear = (evt.req_type == REQ_KEY) && st.key_seen
                       && (st.last_key != evt.key_code);
    assign long_hold = st.hold_count > iv;
    assign tl_dec    = (st.timeout_left != 16'd0) ? st.timeout_left - 16'd1
                                                  : st.timeout_left;

    always_comb
    begin
        st_next = st;
        bits_w  = key_clear ? '0 : sym_bits;
        cnt_w   = key_clear ? '0 : sym_count;
        act     = ACT_NONE;
        rep     = 1'b0;

        if (evt.req_type == REQ_KEY)
        begin
            st_next.last_key = evt.key_code;
            st_next.key_seen = 1'b1;
            case (evt.key_value)
                KEY_REPEAT:
                begin
                    if (st.hold_count == 8'd0)
                    begin
                        if (cnt_w < CNT_W'(MAX_SYMBOLS))
                        begin
                            bits_w = {bits_w[MAX_SYMBOLS-2:0], 1'b1};
                            cnt_w  = cnt_w + CNT_W'(1);
                        end
                    end
                    else if (st.hold_phase == iv - 8'd1)
                    begin
                        bits_w = '0;
                        cnt_w  = '0;
                        if (evt.key_code == cfg.action_key)
                        begin
                            act = ACT_PLAY_PAUSE;
                        end
                    end
                    st_next.hold_count = count_adv;
                    st_next.hold_phase = phase_adv;
                end
                KEY_PRESS:
                begin
                    st_next.hold_count = 8'd0;
                    st_next.hold_phase = 8'd0;
                end
                KEY_RELEASE:
                begin
                    if (st.hold_count == 8'd0 && cnt_w < CNT_W'(MAX_SYMBOLS))
                    begin
                        bits_w = {bits_w[MAX_SYMBOLS-2:0], 1'b0};
                        cnt_w  = cnt_w + CNT_W'(1);
                    end
                    st_next.hold_count = 8'd0;
                    st_next.hold_phase = 8'd0;
                    rep = 1'b1;
                end
                default:
                begin
                end
            endcase
            st_next.timeout_left  = (cfg.timeout_ticks == 16'd0) ? 16'd1 : cfg.timeout_ticks;
            st_next.timeout_armed = 1'b1;
        end
        else if (st.timeout_armed)
        begin
            st_next.timeout_left = tl_dec;
            if (tl_dec == 16'd0)
            begin
                st_next.timeout_armed = 1'b0;
                if (st.key_seen && st.last_key == cfg.action_key)
                begin
                    if (sym_count == CNT_W'(1) && sym_bits == '0)
                    begin
                        act = ACT_PREVIOUS;
                    end
                    else if (sym_count == CNT_W'(1) && sym_bits == BITS_ONE)
                    begin
                        act = ACT_NEXT;
                    end
                    else
                    begin
                        act = ACT_SEEK_FWD;
                    end
                end
            end
        end
    end

    // widen or cut the stored pattern to the report fields
    if (MAX_SYMBOLS >= PAT_W)
    begin : g_pat_cut
        assign pat_ext = bits_w[PAT_W-1:0];
    end
    else
    begin : g_pat_ext
        assign pat_ext = {{(PAT_W-MAX_SYMBOLS){1'b0}}, bits_w};
    end

    if (CNT_W >= LEN_W)
    begin : g_len_cut
        assign len_ext = cnt_w[LEN_W-1:0];
    end
    else
    begin : g_len_ext
        assign len_ext = {{(LEN_W-CNT_W){1'b0}}, cnt_w};
    end

    always_comb
    begin
        sym_bits_next  = bits_w;
        sym_count_next = cnt_w;
        // tick expiry and long hold release both drop the pattern
        if (evt.req_type == REQ_TICK)
        begin
            if (st.timeout_armed && tl_dec == 16'd0)
            begin
                sym_bits_next  = '0;
                sym_count_next = '0;
            end
        end
        else if (rep && long_hold)
        begin
            sym_bits_next  = '0;
            sym_count_next = '0;
        end
    end

    always_comb
    begin
        res.action       = act;
        res.report_valid = rep;
        res.report_key   = rep ? evt.key_code : '0;
        res.pattern_bits = rep ? pat_ext : '0;
        res.pattern_len  = rep ? len_ext : '0;
    end

endmodule

@@ design/key_tap_hold_pattern_detector.sv @@
// ----------------------------------------------------------------------------
// key_tap_hold_pattern_detector
// a request passes the input register, then the result register, before its result is valid
// throughput: one request per cycle, limited by nothing but res_stall
// the state update for a request happens as it leaves the input register
// reset: async active low, registers back to 10 / 300 / 34, pattern cleared
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module key_tap_hold_pattern_detector #(
    parameter int MAX_SYMBOLS = kthpd_pkg::MAX_SYMBOLS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            evt_valid,
    output logic                            evt_stall,
    input  kthpd_pkg::evt_t                 evt_data,
    output logic                            res_valid,
    input  logic                            res_stall,
    output kthpd_pkg::res_t                 res_data,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [kthpd_pkg::ADDR_W-1:0]    paddr,
    input  logic [kthpd_pkg::DATA_W-1:0]    pwdata,
    output logic [kthpd_pkg::DATA_W-1:0]    prdata,
    output logic                            pready
);
    import kthpd_pkg::*;

    localparam int CNT_W = $clog2(MAX_SYMBOLS + 1);

    cfg_t                   cfg_reg;
    logic                   s1_valid_reg;
    logic                   s1_valid_next;
    evt_t                   s1_data_reg;
    logic                   res_valid_reg;
    logic                   res_valid_next;
    res_t                   res_data_reg;
    ctl_state_t             st_reg;
    ctl_state_t             st_next;
    logic [MAX_SYMBOLS-1:0] sym_bits_reg;
    logic [MAX_SYMBOLS-1:0] sym_bits_next;
    logic [CNT_W-1:0]       sym_count_reg;
    logic [CNT_W-1:0]       sym_count_next;
    res_t                   step_res;
    logic                   res_load;
    logic                   s1_fire;
    logic                   evt_fire;
    logic                   cfg_write;
    logic [1:0]             reg_idx;

    assign reg_idx   = paddr[ADDR_W-1:2];
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.repeat_interval <= REPEAT_INTERVAL_RST;
            cfg_reg.timeout_ticks   <= TIMEOUT_TICKS_RST;
            cfg_reg.action_key      <= ACTION_KEY_RST;
        end
        else if (cfg_write)
        begin
            case (reg_idx)
                REG_REPEAT_INTERVAL: cfg_reg.repeat_interval <= pwdata[7:0];
                REG_TIMEOUT_TICKS:   cfg_reg.timeout_ticks   <= pwdata[15:0];
                REG_ACTION_KEY:      cfg_reg.action_key      <= pwdata[KEY_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_REPEAT_INTERVAL: prdata = {{(DATA_W-8){1'b0}}, cfg_reg.repeat_interval};
            REG_TIMEOUT_TICKS:   prdata = {{(DATA_W-16){1'b0}}, cfg_reg.timeout_ticks};
            REG_ACTION_KEY:      prdata = {{(DATA_W-KEY_W){1'b0}}, cfg_reg.action_key};
            default:             prdata = '0;
        endcase
    end

    // handshake between input register and result register
    assign res_load  = !res_valid_reg || !res_stall;
    assign s1_fire   = s1_valid_reg && res_load;
    assign evt_stall = s1_valid_reg && !res_load;
    assign evt_fire  = evt_valid && !evt_stall;

    assign s1_valid_next  = evt_fire || (s1_valid_reg && !s1_fire);
    assign res_valid_next = s1_fire || (res_valid_reg && res_stall);

    kthpd_step #(
        .MAX_SYMBOLS(MAX_SYMBOLS)
    ) u_step (
        .cfg           (cfg_reg),
        .evt           (s1_data_reg),
        .st            (st_reg),
        .sym_bits      (sym_bits_reg),
        .sym_count     (sym_count_reg),
        .st_next       (st_next),
        .sym_bits_next (sym_bits_next),
        .sym_count_next(sym_count_next),
        .res           (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            st_reg        <= '0;
            sym_bits_reg  <= '0;
            sym_count_reg <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
            if (s1_fire)
            begin
                st_reg        <= st_next;
                sym_bits_reg  <= sym_bits_next;
                sym_count_reg <= sym_count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (evt_fire)
        begin
            s1_data_reg <= evt_data;
        end
        if (s1_fire)
        begin
            res_data_reg <= step_res;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

endmodule

@@ design/kthpd_checker.sv @@
// ----------------------------------------------------------------------------
// kthpd_checker
// port-level checks on the request and result channels of the pattern detector
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "key_tap_hold_pattern_detector_macros.svh"

module kthpd_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            evt_valid,
    input logic            evt_stall,
    input kthpd_pkg::evt_t evt_data,
    input logic            res_valid,
    input logic            res_stall,
    input kthpd_pkg::res_t res_data
);
    import kthpd_pkg::*;

    // a stalled request holds
    `KTHPD_ASSERT_NXT(a_req_hold, clk, rst_n, evt_valid && evt_stall, evt_valid && $stable(evt_data))

    // a stalled result holds
    `KTHPD_ASSERT_NXT(a_res_hold, clk, rst_n, res_valid && res_stall, res_valid && $stable(res_data))

    // no report means empty report fields
    `KTHPD_ASSERT_IMP(a_no_report_zero, clk, rst_n, res_valid && !res_data.report_valid, res_data.report_key == '0 && res_data.pattern_bits == '0 && res_data.pattern_len == '0)

    // releases never fire an action
    `KTHPD_ASSERT_IMP(a_report_no_action, clk, rst_n, res_valid && res_data.report_valid, res_data.action == ACT_NONE)

    // an empty pattern carries no symbols
    `KTHPD_ASSERT_IMP(a_empty_pattern, clk, rst_n, res_valid && res_data.report_valid && res_data.pattern_len == '0, res_data.pattern_bits == '0)

endmodule

bind key_tap_hold_pattern_detector kthpd_checker u_kthpd_checker (.*);
